// File: rtl/core/scr_pkg.sv
package scr_pkg;

	// Pot geometry
	localparam int POT_STEPS = 64;
	localparam int POT_W     = $clog2(POT_STEPS);

	typedef logic [POT_W-1:0] pot_t;

	localparam pot_t POT_MAX   = pot_t'(POT_STEPS - 1);
	localparam pot_t POT_RESET = pot_t'((63 > POT_STEPS - 1) ? POT_STEPS - 1 : 63);
	localparam pot_t POT_SHIFT = pot_t'(10);

	// Field widths
	localparam int BAND_W = 10;
	localparam int TRIP_W = 16;
	localparam int PARK_W = 6;
	localparam int CUR_W  = 16;
	localparam int CMD_W  = 8;
	localparam int TGT_W  = 9;
	localparam int CNT_W  = 8;
	localparam int ACT_W  = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int IN_BITS     = CUR_W + CMD_W;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = 2 * POT_W + TGT_W + CNT_W + 1 + ACT_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Reset values of the configuration registers
	localparam logic [BAND_W-1:0] BAND_RESET = BAND_W'(100);
	localparam logic [TRIP_W-1:0] TRIP_RESET = TRIP_W'(750);
	localparam logic [PARK_W-1:0] PARK_RESET = PARK_W'(20);

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Target table: first entry and spacing, mA
	localparam logic [TGT_W-1:0] TGT_BASE = TGT_W'(150);
	localparam logic [TGT_W-1:0] TGT_STEP = TGT_W'(50);

	typedef enum logic [ACT_W-1:0] {
		ACT_NONE     = 3'd0,
		ACT_PARKED   = 3'd1,
		ACT_TRIP     = 3'd2,
		ACT_UP       = 3'd3,
		ACT_UP_SHIFT = 3'd4,
		ACT_DOWN     = 3'd5,
		ACT_BAND     = 3'd6,
		ACT_CMD      = 3'd7
	} act_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BAND = 2'd0,
		CFG_TRIP = 2'd1,
		CFG_PARK = 2'd2
	} cfg_idx_t;

	// Command characters
	localparam logic [CMD_W-1:0] CMD_PARK     = 8'h70; // p
	localparam logic [CMD_W-1:0] CMD_V_UP     = 8'h75; // u
	localparam logic [CMD_W-1:0] CMD_V_DOWN   = 8'h64; // d
	localparam logic [CMD_W-1:0] CMD_G_DOWN   = 8'h31; // 1
	localparam logic [CMD_W-1:0] CMD_G_UP     = 8'h32; // 2
	localparam logic [CMD_W-1:0] CMD_TGT_OFF  = 8'h30; // 0
	localparam logic [CMD_W-1:0] CMD_TGT_LO   = 8'h33; // 3
	localparam logic [CMD_W-1:0] CMD_TGT_HI   = 8'h39; // 9
	localparam logic [CMD_W-1:0] CMD_AUTO     = 8'h24; // $
	localparam logic [CMD_W-1:0] CMD_HALT     = 8'h78; // x
	localparam logic [CMD_W-1:0] CMD_NOP_O    = 8'h6f; // o
	localparam logic [CMD_W-1:0] CMD_NOP_G    = 8'h67; // g
	localparam logic [CMD_W-1:0] CMD_NOP_R    = 8'h72; // r
	localparam logic [CMD_W-1:0] CMD_NOP_SL   = 8'h2f; // /
	localparam logic [CMD_W-1:0] CMD_NOP_Q    = 8'h3f; // ?
	localparam logic [CMD_W-1:0] CMD_NOP_HASH = 8'h23; // #

	typedef struct packed {
		logic [BAND_W-1:0] band;
		logic [TRIP_W-1:0] trip;
		logic [PARK_W-1:0] park;
	} cfg_t;

	typedef struct packed {
		logic             func;
		logic [CUR_W-1:0] current;
		logic [CMD_W-1:0] cmd;
	} item_t;

	typedef struct packed {
		pot_t             volt;
		pot_t             gain;
		logic [TGT_W-1:0] tgt;
		logic [CNT_W-1:0] cnt;
		logic             auto_on;
		act_t             act;
	} result_t;

	function automatic pot_t pot_inc(input pot_t p);
		return (p >= POT_MAX) ? POT_MAX : p + pot_t'(1);
	endfunction

	function automatic pot_t pot_dec(input pot_t p, input pot_t n);
		return (p > n) ? p - n : '0;
	endfunction

	// '3'..'9' map to 150..450 mA in 50 mA steps; only called inside that range
	function automatic logic [TGT_W-1:0] target_of(input logic [CMD_W-1:0] c);
		logic [CMD_W-1:0] k;
		k = c - CMD_TGT_LO;
		return TGT_BASE + TGT_W'(k[2:0]) * TGT_STEP;
	endfunction

endpackage

// File: rtl/core/scr_cfg.sv
module scr_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [scr_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [scr_pkg::CFG_DATA_W-1:0]   wr_data,
	output scr_pkg::cfg_t                    cfg
);

	scr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band <= scr_pkg::BAND_RESET;
			cfg_q.trip <= scr_pkg::TRIP_RESET;
			cfg_q.park <= scr_pkg::PARK_RESET;
		end else if (wr_en) begin
			case (wr_index)
				scr_pkg::CFG_BAND: cfg_q.band <= wr_data[scr_pkg::BAND_W-1:0];
				scr_pkg::CFG_TRIP: cfg_q.trip <= wr_data[scr_pkg::TRIP_W-1:0];
				scr_pkg::CFG_PARK: cfg_q.park <= wr_data[scr_pkg::PARK_W-1:0];
				default: ; // unmapped index, dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/scr_engine.sv
module scr_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  scr_pkg::cfg_t    cfg,
	input  scr_pkg::item_t   item,
	input  logic             go,
	output scr_pkg::result_t res
);

	scr_pkg::pot_t                volt_q, gain_q;
	logic [scr_pkg::TGT_W-1:0]    tgt_q;
	logic [scr_pkg::CNT_W-1:0]    cnt_q;
	logic                         auto_q;

	scr_pkg::pot_t                park_pot;
	logic [scr_pkg::CUR_W-1:0]    tgt_ext;
	logic                         below;
	logic [scr_pkg::CUR_W-1:0]    mag;
	scr_pkg::result_t             nxt;

	always_comb begin
		if (int'(cfg.park) > int'(scr_pkg::POT_MAX))
			park_pot = scr_pkg::POT_MAX;
		else
			park_pot = scr_pkg::pot_t'(cfg.park);
	end

	assign tgt_ext = scr_pkg::CUR_W'(tgt_q);
	assign below   = item.current < tgt_ext;
	assign mag     = below ? tgt_ext - item.current : item.current - tgt_ext;

	always_comb begin
		nxt.volt    = volt_q;
		nxt.gain    = gain_q;
		nxt.tgt     = tgt_q;
		nxt.cnt     = cnt_q;
		nxt.auto_on = auto_q;
		nxt.act     = scr_pkg::ACT_NONE;
		if (!item.func) begin
			if (auto_q) begin
				if (tgt_q == '0) begin
					nxt.volt = park_pot;
					nxt.gain = park_pot;
					nxt.act  = scr_pkg::ACT_PARKED;
				end else if (item.current > cfg.trip) begin
					nxt.volt = park_pot;
					nxt.gain = park_pot;
					if (cnt_q != scr_pkg::CNT_MAX)
						nxt.cnt = cnt_q + scr_pkg::CNT_W'(1);
					nxt.act = scr_pkg::ACT_TRIP;
				end else if (mag < scr_pkg::CUR_W'(cfg.band)) begin
					nxt.act = scr_pkg::ACT_BAND;
				end else if (below) begin
					if (volt_q >= scr_pkg::POT_MAX) begin
						// top of range: back off and move one gain step
						nxt.volt = scr_pkg::pot_inc(
							scr_pkg::pot_dec(volt_q, scr_pkg::POT_SHIFT));
						nxt.gain = scr_pkg::pot_inc(gain_q);
						nxt.act  = scr_pkg::ACT_UP_SHIFT;
					end else begin
						nxt.volt = scr_pkg::pot_inc(volt_q);
						nxt.act  = scr_pkg::ACT_UP;
					end
				end else begin
					nxt.volt = scr_pkg::pot_dec(volt_q, scr_pkg::pot_t'(1));
					nxt.act  = scr_pkg::ACT_DOWN;
				end
			end
		end else begin
			nxt.act = scr_pkg::ACT_CMD;
			case (item.cmd) inside
				scr_pkg::CMD_PARK: begin
					nxt.volt = park_pot;
					nxt.gain = park_pot;
				end
				scr_pkg::CMD_V_UP:    nxt.volt = scr_pkg::pot_inc(volt_q);
				scr_pkg::CMD_V_DOWN:  nxt.volt = scr_pkg::pot_dec(volt_q, scr_pkg::pot_t'(1));
				scr_pkg::CMD_G_DOWN:  nxt.gain = scr_pkg::pot_dec(gain_q, scr_pkg::pot_t'(1));
				scr_pkg::CMD_G_UP:    nxt.gain = scr_pkg::pot_inc(gain_q);
				scr_pkg::CMD_TGT_OFF: nxt.tgt  = '0;
				[scr_pkg::CMD_TGT_LO:scr_pkg::CMD_TGT_HI]:
					nxt.tgt = scr_pkg::target_of(item.cmd);
				scr_pkg::CMD_AUTO:    nxt.auto_on = ~auto_q;
				scr_pkg::CMD_HALT: begin
					nxt.tgt  = '0;
					nxt.volt = park_pot;
					nxt.gain = park_pot;
				end
				scr_pkg::CMD_NOP_O, scr_pkg::CMD_NOP_G, scr_pkg::CMD_NOP_R,
				scr_pkg::CMD_NOP_SL, scr_pkg::CMD_NOP_Q, scr_pkg::CMD_NOP_HASH: ;
				default: nxt.act = scr_pkg::ACT_NONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volt_q <= scr_pkg::POT_RESET;
			gain_q <= scr_pkg::POT_RESET;
			tgt_q  <= '0;
			cnt_q  <= '0;
			auto_q <= 1'b1;
		end else if (go) begin
			volt_q <= nxt.volt;
			gain_q <= nxt.gain;
			tgt_q  <= nxt.tgt;
			cnt_q  <= nxt.cnt;
			auto_q <= nxt.auto_on;
		end
	end

	assign res = nxt;

endmodule

// File: rtl/core/shunt_current_regulator.sv
// Channel  Dir  Handshake                 Payload
// s_       in   s_tvalid / s_tready       s_tdata: measured_current, command_byte
//                                         s_tuser: func
// m_       out  m_tvalid / m_tready       m_tdata: voltage_pot .. action
// cfg_     in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One transfer in, one transfer out; sustained rate one item per clock while m_tready stays high.
// Each item passes the input register, then the result register, with the
// state update done in the single compare-and-adjust pass between them.
// While a result waits, the input register takes one more item and then
// s_tready drops until the result transfer goes.
// arst_n clears handshake state and the regulator state (pots 63, target 0,
// count 0, automatic on); configuration returns to 100 / 750 / 20.
module shunt_current_regulator (
	input  logic                               clk,
	input  logic                               arst_n,
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [15:0] measured_current, [23:16] command_byte
	input  logic [scr_pkg::IN_TDATA_W-1:0]     s_tdata,
	// [0] func
	input  logic                               s_tuser,
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [5:0] voltage_pot, [11:6] gain_pot, [20:12] target_current,
	// [28:21] overcurrent_events, [29] auto_mode, [32:30] action, rest zero
	output logic [scr_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// configuration writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [scr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [scr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	scr_pkg::cfg_t    cfg;
	scr_pkg::item_t   item_s1;
	logic             valid_s1;
	scr_pkg::result_t res_nxt;
	scr_pkg::result_t res_q;
	logic             out_valid_q;
	logic             s_xfer;
	logic             adv;

	// Config is always writable; writes should only come while the block is quiet, which the block does not enforce.
	assign cfg_ready = 1'b1;

	scr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Input stage moves on when the result slot is empty or being drained.
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign s_xfer   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_xfer)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			item_s1.func    <= s_tuser;
			item_s1.current <= s_tdata[scr_pkg::CUR_W-1:0];
			item_s1.cmd     <= s_tdata[scr_pkg::IN_BITS-1:scr_pkg::CUR_W];
		end
	end

	scr_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.go     (adv),
		.res    (res_nxt)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res_nxt;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = scr_pkg::OUT_TDATA_W'({res_q.act, res_q.auto_on, res_q.cnt,
		res_q.tgt, res_q.gain, res_q.volt});

	// Parking and trips always leave both pots on the same position.
	a_park_equal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.act == scr_pkg::ACT_PARKED || res_q.act == scr_pkg::ACT_TRIP)
		|-> res_q.volt == res_q.gain)
		else $error("parked result with unequal pots");

	// The trip count only moves on an advancing tick that tripped.
	a_cnt_on_trip: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (res_nxt.cnt != u_engine.cnt_q)
		|-> res_nxt.act == scr_pkg::ACT_TRIP)
		else $error("trip count changed without a trip");

	// An empty input stage never refuses a transfer.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input refused while stage empty");

	// A stalled result does not lose the item waiting behind it.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_tready |=> valid_s1)
		else $error("queued item dropped during stall");

endmodule

// File: test/tb_shunt_current_regulator.sv
`timescale 1ns / 100ps

// Checks the shunt regulator stream by stream. A scoreboard model works out the
// state after each accepted input transfer. Every result transfer is compared,
// field by field, with the oldest reading that is still outstanding.
module tb_shunt_current_regulator;

	localparam int CUR_W       = scr_pkg::CUR_W;
	localparam int CMD_W       = scr_pkg::CMD_W;
	localparam int BAND_W      = scr_pkg::BAND_W;
	localparam int TRIP_W      = scr_pkg::TRIP_W;
	localparam int PARK_W      = scr_pkg::PARK_W;
	localparam int CFG_IDX_W   = scr_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W  = scr_pkg::CFG_DATA_W;
	localparam int IN_TDATA_W  = scr_pkg::IN_TDATA_W;
	localparam int OUT_TDATA_W = scr_pkg::OUT_TDATA_W;
	localparam int OUT_BITS    = scr_pkg::OUT_BITS;

	localparam int CLK_HALF    = 6;
	localparam int RESET_TICKS = 3;
	localparam int CYCLE_LIMIT = 300000;
	localparam int TAIL_CYCLES = 8;     // settling margin after the last result
	localparam int HOLD_CYCLES = 300;   // long output hold-off
	localparam int POT_TOP     = scr_pkg::POT_STEPS - 1;
	localparam int TGT_BASE_MA = 150;
	localparam int TGT_STEP_MA = 50;
	localparam int SHIFT_DROP  = 10;
	localparam int CUR_TOP     = (1 << CUR_W) - 1;

	typedef enum int {RX_FREE, RX_COIN, RX_PATTERN} rx_mode_t;

	// One expected result: the regulator state after an item, plus its action
	typedef struct {
		int            volt;
		int            gain;
		int            tgt;
		int            trips;
		int            auto_on;
		scr_pkg::act_t act;
	} reading_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_TDATA_W-1:0] s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Scoreboard copy of the regulator state and its registers
	int volt_pos    = int'(scr_pkg::POT_RESET);
	int gain_pos    = int'(scr_pkg::POT_RESET);
	int tgt_ma      = 0;
	int trip_events = 0;
	int auto_on     = 1;
	int band_ma     = int'(scr_pkg::BAND_RESET);
	int trip_ma     = int'(scr_pkg::TRIP_RESET);
	int park_pos    = int'(scr_pkg::PARK_RESET);

	reading_t pending_readings[$];

	int errors       = 0;
	int items_sent   = 0;
	int results_seen = 0;
	int input_stalls = 0;
	int act_seen[8]  = '{default: 0};

	// sender burst control
	int burst_left = 0;
	bit gaps_off   = 1'b0;

	// receiver stall control
	bit       hold_req  = 1'b0;
	int       hold_left = 0;
	int       mode_left = 0;
	rx_mode_t rx_mode   = RX_FREE;
	logic [7:0] rx_mask = 8'hff;

	shunt_current_regulator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// ---------------------------------------------------------------- model

	// both pots to the park position, clipped to the pot range
	function automatic void park_both();
		int p;
		p = (park_pos > POT_TOP) ? POT_TOP : park_pos;
		volt_pos = p;
		gain_pos = p;
	endfunction

	// Applies one item to the scoreboard state and returns what should come out
	function automatic reading_t regulate_item(input logic func,
			input logic [CUR_W-1:0] cur, input logic [CMD_W-1:0] cmd);
		reading_t      r;
		scr_pkg::act_t act;
		int            diff;
		int            mag;
		act = scr_pkg::ACT_NONE;
		if (!func) begin
			if (auto_on == 0) begin
				act = scr_pkg::ACT_NONE;
			end else if (tgt_ma == 0) begin
				// zero target parks, even above the trip level
				park_both();
				act = scr_pkg::ACT_PARKED;
			end else if (int'(cur) > trip_ma) begin
				park_both();
				if (trip_events < int'(scr_pkg::CNT_MAX))
					trip_events++;
				act = scr_pkg::ACT_TRIP;
			end else begin
				diff = int'(cur) - tgt_ma;
				mag  = (diff < 0) ? -diff : diff;
				if (mag < band_ma) begin
					act = scr_pkg::ACT_BAND;
				end else if (diff < 0) begin
					act = scr_pkg::ACT_UP;
					// voltage pot at full scale: back off and move gain up a notch
					if (volt_pos >= POT_TOP) begin
						volt_pos = (volt_pos > SHIFT_DROP) ? volt_pos - SHIFT_DROP : 0;
						gain_pos = (gain_pos >= POT_TOP) ? POT_TOP : gain_pos + 1;
						act = scr_pkg::ACT_UP_SHIFT;
					end
					volt_pos = (volt_pos >= POT_TOP) ? POT_TOP : volt_pos + 1;
				end else begin
					volt_pos = (volt_pos > 0) ? volt_pos - 1 : 0;
					act = scr_pkg::ACT_DOWN;
				end
			end
		end else begin
			act = scr_pkg::ACT_CMD;
			case (cmd)
				scr_pkg::CMD_PARK:    park_both();
				scr_pkg::CMD_V_UP:    volt_pos = (volt_pos >= POT_TOP) ? POT_TOP : volt_pos + 1;
				scr_pkg::CMD_V_DOWN:  volt_pos = (volt_pos > 0) ? volt_pos - 1 : 0;
				scr_pkg::CMD_G_DOWN:  gain_pos = (gain_pos > 0) ? gain_pos - 1 : 0;
				scr_pkg::CMD_G_UP:    gain_pos = (gain_pos >= POT_TOP) ? POT_TOP : gain_pos + 1;
				scr_pkg::CMD_TGT_OFF: tgt_ma = 0;
				scr_pkg::CMD_AUTO:    auto_on = 1 - auto_on;
				scr_pkg::CMD_HALT: begin
					tgt_ma = 0;
					park_both();
				end
				scr_pkg::CMD_NOP_O, scr_pkg::CMD_NOP_G, scr_pkg::CMD_NOP_R,
				scr_pkg::CMD_NOP_SL, scr_pkg::CMD_NOP_Q, scr_pkg::CMD_NOP_HASH: ;
				default: begin
					if (cmd >= scr_pkg::CMD_TGT_LO && cmd <= scr_pkg::CMD_TGT_HI)
						tgt_ma = TGT_BASE_MA
							+ int'(cmd - scr_pkg::CMD_TGT_LO) * TGT_STEP_MA;
					else
						act = scr_pkg::ACT_NONE;   // unknown byte, ignored
				end
			endcase
		end
		r.volt    = volt_pos;
		r.gain    = gain_pos;
		r.tgt     = tgt_ma;
		r.trips   = trip_events;
		r.auto_on = auto_on;
		r.act     = act;
		return r;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			errors++;
		end
	endtask

	// Register writes, result checks and input predictions all at the clock edge,
	// in that order, so the model sees exactly what the block sees.
	always @(posedge clk) begin : monitor
		reading_t want;
		if (cfg_valid && cfg_ready) begin
			case (scr_pkg::cfg_idx_t'(cfg_index))
				scr_pkg::CFG_BAND: band_ma  = int'(cfg_data[BAND_W-1:0]);
				scr_pkg::CFG_TRIP: trip_ma  = int'(cfg_data[TRIP_W-1:0]);
				scr_pkg::CFG_PARK: park_pos = int'(cfg_data[PARK_W-1:0]);
				default: ;
			endcase
		end
		if (s_tvalid && !s_tready)
			input_stalls++;
		if (m_tvalid && m_tready) begin
			results_seen++;
			if (pending_readings.size() == 0) begin
				$error("result transfer with nothing outstanding: tdata %h", m_tdata);
				errors++;
			end else begin
				want = pending_readings.pop_front();
				act_seen[int'(want.act)]++;
				// [5:0] volt, [11:6] gain, [20:12] target, [28:21] count,
				// [29] auto, [32:30] action, zero above
				check_field("voltage_pot",        want.volt,    int'(m_tdata[5:0]));
				check_field("gain_pot",           want.gain,    int'(m_tdata[11:6]));
				check_field("target_current",     want.tgt,     int'(m_tdata[20:12]));
				check_field("overcurrent_events", want.trips,   int'(m_tdata[28:21]));
				check_field("auto_mode",          want.auto_on, int'(m_tdata[29]));
				check_field("action",             int'(want.act), int'(m_tdata[32:30]));
				check_field("tdata padding",      0, int'(m_tdata[OUT_TDATA_W-1:OUT_BITS]));
			end
		end
		if (s_tvalid && s_tready)
			pending_readings.push_back(regulate_item(s_tuser, s_tdata[CUR_W-1:0],
				s_tdata[CUR_W+CMD_W-1:CUR_W]));
	end

	// ---------------------------------------------------------------- receiver

	// Mixes free-running, coin-toss and rotating-mask stalls; a hold-off
	// request from the sequencer blocks the output until the hold-off count runs out.
	always @(posedge clk) begin : receiver
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode   = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(8, 64);
				rx_mask   = 8'($urandom) | 8'h01;
			end
			mode_left--;
			case (rx_mode)
				RX_FREE: m_tready <= 1'b1;
				RX_COIN: m_tready <= 1'($urandom_range(0, 1));
				default: begin
					m_tready <= rx_mask[0];
					rx_mask = {rx_mask[0], rx_mask[7:1]};
				end
			endcase
		end
	end

	// ---------------------------------------------------------------- sender

	// Offers one item and returns at the edge of its transfer with tvalid still
	// high. Between bursts it drops tvalid for a random gap.
	task automatic send_item(input logic func, input logic [CUR_W-1:0] cur,
			input logic [CMD_W-1:0] cmd);
		if (!gaps_off && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		if (burst_left != 0)
			burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= IN_TDATA_W'({cmd, cur});
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic send_tick(input int cur);
		send_item(1'b0, CUR_W'(cur), CMD_W'($urandom));
	endtask

	task automatic send_cmd(input logic [CMD_W-1:0] cmd);
		send_item(1'b1, CUR_W'($urandom), cmd);
	endtask

	// stop offering and wait for every outstanding result
	task automatic settle();
		s_tvalid <= 1'b0;
		while (results_seen < items_sent) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input scr_pkg::cfg_idx_t idx,
			input logic [CFG_DATA_W-1:0] word);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= word;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// all three registers; unused upper data bits carry noise
	task automatic load_settings(input int band, input int trip, input int park);
		logic [CFG_DATA_W-1:0] w_band;
		logic [CFG_DATA_W-1:0] w_park;
		w_band = CFG_DATA_W'($urandom);
		w_park = CFG_DATA_W'($urandom);
		w_band[BAND_W-1:0] = BAND_W'(band);
		w_park[PARK_W-1:0] = PARK_W'(park);
		write_reg(scr_pkg::CFG_BAND, w_band);
		write_reg(scr_pkg::CFG_TRIP, CFG_DATA_W'(trip));
		write_reg(scr_pkg::CFG_PARK, w_park);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [CMD_W-1:0] any_command(input int pick);
		case (pick)
			0:  return scr_pkg::CMD_PARK;
			1:  return scr_pkg::CMD_V_UP;
			2:  return scr_pkg::CMD_V_DOWN;
			3:  return scr_pkg::CMD_G_DOWN;
			4:  return scr_pkg::CMD_G_UP;
			5:  return scr_pkg::CMD_TGT_OFF;
			6:  return scr_pkg::CMD_AUTO;
			7:  return scr_pkg::CMD_HALT;
			8:  return scr_pkg::CMD_NOP_O;
			9:  return scr_pkg::CMD_NOP_G;
			10: return scr_pkg::CMD_NOP_R;
			11: return scr_pkg::CMD_NOP_SL;
			12: return scr_pkg::CMD_NOP_Q;
			13: return scr_pkg::CMD_NOP_HASH;
			default: return scr_pkg::CMD_TGT_LO + CMD_W'($urandom_range(0, 6));
		endcase
	endfunction

	// Mostly regulation ticks around the live target so the pots wander over
	// their range; pulls the block back into automatic mode with a target set
	// when it drifts out, plus some garbage bytes.
	task automatic random_item();
		int sel;
		int cur;
		int span;
		sel = $urandom_range(0, 99);
		if (auto_on == 0 && sel < 60) begin
			send_cmd(scr_pkg::CMD_AUTO);
		end else if (tgt_ma == 0 && sel < 70) begin
			send_cmd(scr_pkg::CMD_TGT_LO + CMD_W'($urandom_range(0, 6)));
		end else if (sel < 4) begin
			send_item(1'($urandom), CUR_W'($urandom), CMD_W'($urandom));
		end else if (sel < 24) begin
			send_cmd(any_command($urandom_range(0, 16)));
		end else begin
			span = band_ma + 40;
			case ($urandom_range(0, 9))
				0:       cur = int'($urandom_range(0, CUR_TOP));
				1:       cur = trip_ma + int'($urandom_range(0, 3)) - 1; // around the trip edge
				2, 3, 4: cur = tgt_ma + int'($urandom_range(0, 2 * span)) - span;
				default: cur = int'($urandom_range(0, tgt_ma));          // at or below target
			endcase
			if (cur < 0)
				cur = 0;
			if (cur > CUR_TOP)
				cur = CUR_TOP;
			send_tick(cur);
		end
	endtask

	task automatic run_phase(input int band, input int trip, input int park, input int count);
		settle();
		load_settings(band, trip, park);
		repeat (count) random_item();
	endtask

	// ---------------------------------------------------------------- tests

	// Park at full scale so the first step up lands on the gain shift.
	task automatic test_regulation_cases();
		load_settings(int'(scr_pkg::BAND_RESET), int'(scr_pkg::TRIP_RESET), POT_TOP);
		send_tick(1000);              // zero target parks, ahead of trip
		send_cmd(scr_pkg::CMD_TGT_HI); // 450 mA
		send_tick(0);                 // pot at full scale: gain shift
		send_tick(449);               // inside the band
		send_tick(0);                 // plain step up
		send_tick(750);               // equal to trip level: step down, no trip
		send_tick(751);               // just above trip
		send_tick(CUR_TOP);           // top of the current range
	endtask

	task automatic test_command_set();
		send_cmd(scr_pkg::CMD_V_DOWN);
		send_cmd(scr_pkg::CMD_V_UP);
		send_cmd(scr_pkg::CMD_G_DOWN);
		send_cmd(scr_pkg::CMD_G_UP);
		send_cmd(scr_pkg::CMD_PARK);
		send_cmd(scr_pkg::CMD_NOP_O);
		send_cmd(scr_pkg::CMD_NOP_G);
		send_cmd(scr_pkg::CMD_NOP_R);
		send_cmd(scr_pkg::CMD_NOP_SL);
		send_cmd(scr_pkg::CMD_NOP_Q);
		send_cmd(scr_pkg::CMD_NOP_HASH);
		send_cmd(scr_pkg::CMD_TGT_LO);
		send_cmd(scr_pkg::CMD_AUTO);  // manual mode
		send_tick(0);                 // ignored in manual mode
		send_cmd(scr_pkg::CMD_AUTO);
		send_cmd(scr_pkg::CMD_HALT);
		send_cmd(scr_pkg::CMD_TGT_OFF);
		send_cmd(8'hff);              // unknown bytes do nothing
		send_cmd(8'h00);
	endtask

	// Register settings include both ends of every range: no dead band and
	// the widest, trip at zero and at the top, park at zero and at full scale.
	task automatic test_random_traffic();
		run_phase(int'(scr_pkg::BAND_RESET), int'(scr_pkg::TRIP_RESET),
			int'(scr_pkg::PARK_RESET), 260);
		run_phase(0, CUR_TOP, POT_TOP, 260);
		run_phase((1 << BAND_W) - 1, 0, 0, 200);
		run_phase(1, CUR_TOP - 1, 1, 260);
		run_phase(37, 400, 45, 260);
		run_phase($urandom_range(0, (1 << BAND_W) - 1), $urandom_range(300, CUR_TOP),
			$urandom_range(0, POT_TOP), 260);
	endtask

	// Output blocked for a long stretch while items keep coming back to back,
	// so the pipeline fills and the input has to stall.
	task automatic test_output_backpressure();
		settle();
		load_settings(int'(scr_pkg::BAND_RESET), int'(scr_pkg::TRIP_RESET),
			int'(scr_pkg::PARK_RESET));
		hold_req = 1'b1;
		gaps_off = 1'b1;
		repeat (40) random_item();
		gaps_off = 1'b0;
	endtask

	// ---------------------------------------------------------------- run

	initial begin : sequencer
		repeat (RESET_TICKS) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_regulation_cases();
		test_command_set();
		test_random_traffic();
		test_output_backpressure();
		settle();
		$display("Checked %0d results from %0d items over eight register loads",
			results_seen, items_sent);
		$display("Actions none/park/trip/up/shift/down/band/cmd: %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d",
			act_seen[0], act_seen[1], act_seen[2], act_seen[3], act_seen[4],
			act_seen[5], act_seen[6], act_seen[7]);
		$display("Input stalled %0d cycles", input_stalls);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$error("timed out after %0d cycles: %0d items sent, %0d results seen",
			CYCLE_LIMIT, items_sent, results_seen);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
